FILE: design/sras_pkg.sv
package sras_pkg;

  localparam logic [1:0] ACT_SEND    = 2'd0;
  localparam logic [1:0] ACT_ACK     = 2'd1;
  localparam logic [1:0] ACT_TIMEOUT = 2'd2;

  localparam logic [2:0] ST_SENT    = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_NEWACK  = 3'd2;
  localparam logic [2:0] ST_IGNORED = 3'd3;
  localparam logic [2:0] ST_CORRUPT = 3'd4;
  localparam logic [2:0] ST_RESENT  = 3'd5;
  localparam logic [2:0] ST_IDLE    = 3'd6;

  localparam logic [1:0] TM_NONE    = 2'd0;
  localparam logic [1:0] TM_START   = 2'd1;
  localparam logic [1:0] TM_STOP    = 2'd2;
  localparam logic [1:0] TM_RESTART = 2'd3;

  localparam logic [15:0] NO_ACK_NUM = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  pkt_seq;
    logic [3:0]  pkt_ack;
    logic signed [15:0] pkt_checksum;
    logic [63:0] payload_low;
    logic [63:0] payload_mid;
    logic [31:0] payload_top;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        tx_valid;
    logic [3:0]  tx_seq;
    logic signed [15:0] tx_checksum;
    logic [63:0] tx_payload_low;
    logic [63:0] tx_payload_mid;
    logic [31:0] tx_payload_top;
    logic [1:0]  timer_cmd;
  } rsp_t;

  // stored packet: seq, checksum, payload
  typedef struct packed {
    logic [3:0]  seq;
    logic [15:0] checksum;
    logic [63:0] payload_low;
    logic [63:0] payload_mid;
    logic [31:0] payload_top;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // controller to datapath
  typedef struct packed {
    logic load_req;     // capture request, start byte sum
    logic acc_step;     // add one payload group to the sum
    logic ram_rd;       // read slot at base + off
    logic ram_wr;       // write new entry at last + 1
    logic do_send;      // commit a send
    logic mark_ack;     // set acked bit, update counts
    logic slide_step;   // free base entry
    logic scan_step;    // advance scan offset
    logic scan_clr;
    logic rd_first;     // read base slot
    logic rd_last;      // read last slot
    logic rd_ack;       // read acked slot
    logic [2:0] status;
    logic [1:0] timer_cmd;
    logic emit;         // emit entry read from RAM
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       sum_done;
    logic       cs_match;
    logic       full;
    logic       unacked_zero;
    logic       unacked_one;
    logic       base_acked;
    logic       acked_nonzero;
    logic       scan_hit;
    logic       scan_end;
    logic       ack_ok;
    logic       off_zero;
  } sts_t;

endpackage

FILE: design/sras_ram.sv
module sras_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: design/sras_ctrl.sv
module sras_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            out_busy,
  output sras_pkg::cmd_t  cmd,
  input  sras_pkg::sts_t  sts
);
  import sras_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SUM   = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_RDF   = 4'd3;
  localparam logic [3:0] S_CHK   = 4'd5;
  localparam logic [3:0] S_SLIDE = 4'd6;
  localparam logic [3:0] S_SCAN  = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;
  localparam logic [3:0] S_RDW   = 4'd10;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        cmd.acc_step = 1'b1;
        if (sts.sum_done) begin
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (!out_busy) begin
          case (sts.action)
            ACT_SEND: begin
              if (sts.full) begin
                cmd.status = ST_FULL;
                cmd.out_load = 1'b1;
                state_next = S_IDLE;
              end else begin
                cmd.ram_wr = 1'b1;
                cmd.do_send = 1'b1;
                cmd.status = ST_SENT;
                cmd.timer_cmd = sts.unacked_zero ? TM_START : TM_NONE;
                cmd.out_load = 1'b1;
                state_next = S_IDLE;
              end
            end
            ACT_ACK: begin
              if (!sts.cs_match) begin
                cmd.status = ST_CORRUPT;
                cmd.out_load = 1'b1;
                state_next = S_IDLE;
              end else if (sts.unacked_zero) begin
                cmd.status = ST_IGNORED;
                cmd.out_load = 1'b1;
                state_next = S_IDLE;
              end else begin
                cmd.rd_first = 1'b1;
                state_next = S_RDF;
              end
            end
            ACT_TIMEOUT: begin
              if (sts.unacked_zero) begin
                cmd.status = ST_IDLE;
                cmd.out_load = 1'b1;
                state_next = S_IDLE;
              end else begin
                cmd.scan_clr = 1'b1;
                state_next = S_SCAN;
              end
            end
            default: begin
              cmd.status = ST_IDLE;
              cmd.out_load = 1'b1;
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_RDF: begin
        // base seq on the read port now, last seq arrives for S_CHK
        cmd.rd_last = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (!sts.ack_ok) begin
          cmd.status = ST_IGNORED;
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.mark_ack = 1'b1;
          if (sts.off_zero) begin
            state_next = S_SLIDE;
          end else begin
            cmd.status = ST_NEWACK;
            cmd.out_load = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_SLIDE: begin
        if (sts.acked_nonzero && sts.base_acked) begin
          cmd.slide_step = 1'b1;
        end else begin
          cmd.status = ST_NEWACK;
          cmd.timer_cmd = sts.unacked_zero ? TM_STOP : TM_RESTART;
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts.scan_end) begin
          cmd.status = ST_IDLE;
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end else if (sts.scan_hit) begin
          cmd.ram_rd = 1'b1;
          state_next = S_RDW;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_RDW: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        cmd.status = ST_RESENT;
        cmd.timer_cmd = TM_START;
        cmd.out_load = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst) begin
      if (state == S_IDLE && in_valid) begin
        assert (state_next == S_SUM) else $error("request not taken");
      end
    end
  end

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("stall low while busy");
  a_out_once: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> (state == S_IDLE)) else $error("result not final");
  a_emit_after_rd: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> $past(state == S_RDW)) else $error("emit without read");
endmodule

FILE: design/sras_dp.sv
module sras_dp #(
  parameter int WINDOW    = 8,
  parameter int SEQ_SPACE = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  sras_pkg::req_t  req,
  input  sras_pkg::cmd_t  cmd,
  output sras_pkg::sts_t  sts,
  input  logic            out_stall,
  output logic            out_valid,
  output sras_pkg::rsp_t  rsp
);
  import sras_pkg::*;

  localparam int SW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW = $clog2(WINDOW + 1);
  localparam int QW = 4;

  req_t        r;
  logic [15:0] sum;
  logic [1:0]  grp;
  logic [SW-1:0] base_slot, last_slot, scan_slot, rd_addr;
  logic [CW-1:0] unacked_count, acked_count, scan_off;
  logic [QW-1:0] next_seq;
  logic [WINDOW-1:0] acked;
  logic [QW-1:0] first_seq;
  entry_t      wr_ent, rd_ent;
  logic [QW-1:0] off_q;
  logic [SW-1:0] ack_slot;
  rsp_t        rsp_next;

  function automatic logic [15:0] bsum8(input logic [63:0] v);
    logic [15:0] s;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 16'(v[8*i +: 8]);
    end
    return s;
  endfunction

  function automatic logic [SW-1:0] wrap(input logic [SW:0] v);
    logic [SW:0] t;
    t = (v >= (SW+1)'(WINDOW)) ? v - (SW+1)'(WINDOW) : v;
    return t[SW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      r <= req;
      grp <= 2'd0;
      sum <= '0;
    end else if (cmd.acc_step) begin
      case (grp)
        2'd0: sum <= sum + bsum8(r.payload_low);
        2'd1: sum <= sum + bsum8(r.payload_mid);
        2'd2: sum <= sum + bsum8({32'd0, r.payload_top});
        default: sum <= sum;
      endcase
      grp <= grp + 2'd1;
    end
  end

  // grp==3 means all payload bytes summed
  assign sts.sum_done = (grp == 2'd3) && cmd.acc_step;
  assign sts.action   = r.action;
  assign sts.cs_match = ((sum + 16'(r.pkt_seq) + 16'(r.pkt_ack)) == r.pkt_checksum);
  assign sts.full     = (32'(unacked_count) + 32'(acked_count)) >= WINDOW;
  assign sts.unacked_zero  = (unacked_count == '0);
  assign sts.unacked_one   = (unacked_count == CW'(1));
  assign sts.base_acked    = acked[base_slot];
  assign sts.acked_nonzero = (acked_count != '0);

  // RAM addressing
  always_comb begin
    rd_addr = scan_slot;
    if (cmd.rd_first) begin
      rd_addr = base_slot;
    end else if (cmd.rd_last) begin
      rd_addr = last_slot;
    end
  end

  assign wr_ent.seq = next_seq;
  assign wr_ent.checksum = sum + 16'(next_seq) + NO_ACK_NUM;
  assign wr_ent.payload_low = r.payload_low;
  assign wr_ent.payload_mid = r.payload_mid;
  assign wr_ent.payload_top = r.payload_top;

  sras_ram #(.WIDTH(ENTRY_W), .DEPTH(WINDOW)) u_ram (
    .clk   (clk),
    .we    (cmd.ram_wr),
    .waddr (wrap({1'b0, last_slot} + (SW+1)'(1))),
    .wdata (wr_ent),
    .raddr (rd_addr),
    .rdata (rd_ent)
  );

  // window check: base seq is registered in first_seq while the last seq is read
  logic [QW-1:0] span_q;
  logic [QW:0]   ack_ext;
  logic [QW:0]   span_w, off_w;
  always_ff @(posedge clk) begin
    if (cmd.rd_last) begin
      first_seq <= rd_ent.seq;
    end
  end
  assign ack_ext = {1'b0, r.pkt_ack};
  always_comb begin
    span_w = {1'b0, rd_ent.seq} + (QW+1)'(SEQ_SPACE) - {1'b0, first_seq};
    if (span_w >= (QW+1)'(SEQ_SPACE)) begin
      span_w = span_w - (QW+1)'(SEQ_SPACE);
    end
    off_w = {1'b0, r.pkt_ack} + (QW+1)'(SEQ_SPACE) - {1'b0, first_seq};
    if (off_w >= (QW+1)'(SEQ_SPACE)) begin
      off_w = off_w - (QW+1)'(SEQ_SPACE);
    end
    span_q = span_w[QW-1:0];
    off_q  = off_w[QW-1:0];
  end
  assign ack_slot = wrap({1'b0, base_slot} + (SW+1)'(off_q));
  assign sts.ack_ok = (ack_ext < (QW+1)'(SEQ_SPACE)) && (off_q <= span_q)
                      && (32'(off_q) < WINDOW) && !acked[ack_slot];
  assign sts.off_zero = (off_q == '0);

  assign scan_slot = wrap({1'b0, base_slot} + (SW+1)'(scan_off));
  assign sts.scan_end = (32'(scan_off) >= WINDOW)
                        || (scan_off >= CW'(32'(unacked_count) + 32'(acked_count)));
  assign sts.scan_hit = !acked[scan_slot];

  always_ff @(posedge clk) begin
    if (rst) begin
      base_slot <= '0;
      last_slot <= SW'(WINDOW - 1);
      unacked_count <= '0;
      acked_count <= '0;
      next_seq <= '0;
      acked <= '0;
      scan_off <= '0;
    end else begin
      if (cmd.do_send) begin
        last_slot <= wrap({1'b0, last_slot} + (SW+1)'(1));
        acked[wrap({1'b0, last_slot} + (SW+1)'(1))] <= 1'b0;
        unacked_count <= unacked_count + CW'(1);
        next_seq <= (32'(next_seq) + 1 >= SEQ_SPACE) ? '0 : next_seq + QW'(1);
      end
      if (cmd.mark_ack) begin
        acked[ack_slot] <= 1'b1;
        unacked_count <= unacked_count - CW'(1);
        acked_count <= acked_count + CW'(1);
      end
      if (cmd.slide_step) begin
        acked[base_slot] <= 1'b0;
        base_slot <= wrap({1'b0, base_slot} + (SW+1)'(1));
        acked_count <= acked_count - CW'(1);
      end
      if (cmd.scan_clr) begin
        scan_off <= '0;
      end else if (cmd.scan_step) begin
        scan_off <= scan_off + CW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    rsp_next = '0;
    rsp_next.status = cmd.status;
    rsp_next.timer_cmd = cmd.timer_cmd;
    if (cmd.do_send) begin
      rsp_next.tx_valid = 1'b1;
      rsp_next.tx_seq = wr_ent.seq;
      rsp_next.tx_checksum = wr_ent.checksum;
      rsp_next.tx_payload_low = wr_ent.payload_low;
      rsp_next.tx_payload_mid = wr_ent.payload_mid;
      rsp_next.tx_payload_top = wr_ent.payload_top;
    end else if (cmd.emit) begin
      rsp_next.tx_valid = 1'b1;
      rsp_next.tx_seq = rd_ent.seq;
      rsp_next.tx_checksum = rd_ent.checksum;
      rsp_next.tx_payload_low = rd_ent.payload_low;
      rsp_next.tx_payload_mid = rd_ent.payload_mid;
      rsp_next.tx_payload_top = rd_ent.payload_top;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp <= rsp_next;
    end
  end

  a_occ: assert property (@(posedge clk) disable iff (rst)
    (32'(unacked_count) + 32'(acked_count)) <= WINDOW) else $error("overfull");
  a_acked_cnt: assert property (@(posedge clk) disable iff (rst)
    $countones(acked) == 32'(acked_count)) else $error("acked count drift");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
endmodule

FILE: design/selective_repeat_arq_sender.sv
// Selective-repeat ARQ sender. One request is one event: a new 20-byte
// message, an arriving ACK, or a retransmit timer expiry; each request
// gives exactly one result. Requests are handled one at a time: after the
// accepting cycle the payload bytes are summed eight per cycle, then a
// send, a corrupted ACK, or an ACK or timeout with nothing outstanding
// finishes at dispatch, and any other ACK is checked against the window
// after the base and last stored packets are read; an accepted base ACK
// slides the window one entry per cycle, and a timeout scans one entry
// per cycle for the oldest unacknowledged packet, then reads it from the
// packet memory. Dispatch waits while the previous result is held.
// Stored packets live in a WINDOW-deep RAM with a registered read port;
// results wait in an output register.
module selective_repeat_arq_sender #(
  parameter int WINDOW    = 8,
  parameter int SEQ_SPACE = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  sras_pkg::req_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output sras_pkg::rsp_t  out_data
);
  import sras_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // controller waits while the previous result is still held
  sras_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_busy (out_valid && out_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  sras_dp #(.WINDOW(WINDOW), .SEQ_SPACE(SEQ_SPACE)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .rsp       (out_data)
  );

  a_one_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(out_data)) else $error("payload moved");
  a_tx_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.tx_valid) |->
      (out_data.status == ST_SENT || out_data.status == ST_RESENT))
    else $error("tx with wrong status");
endmodule
